// ===== hw/rtl/implicit_tree_traversal_assert.svh =====
// Assertion macros for the implicit tree traversal block.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef IMPLICIT_TREE_TRAVERSAL_ASSERT_SVH
`define IMPLICIT_TREE_TRAVERSAL_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ITT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itt: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ITT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itt: next-cycle check failed");

`endif

// ===== hw/rtl/itt_pkg.sv =====
// Shared types and constants for the implicit tree traversal block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package itt_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned CountW   = $clog2(MaxNodes + 1);
  localparam int unsigned AddrW    = $clog2(MaxNodes);
  localparam int unsigned ValueW   = 32;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdDump   = 1'b1;

  typedef enum logic [1:0] {
    OrdPre,
    OrdIn,
    OrdPost
  } order_e;

  typedef enum logic [2:0] {
    PosHold,
    PosRoot,
    PosLeft,
    PosRight,
    PosUp
  } pos_op_e;

  typedef struct packed {
    logic              command;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] node_value;
    order_e             order;
    logic               last;
    logic               full_error;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic    wr_node;
    logic    set_err;
    logic    rd_node;
    pos_op_e pos_op;
    order_e  tag_order;
    logic    tag_last;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic has_left;
    logic has_right;
    logic at_root;
    logic is_left_child;
    logic pend_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/itt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module itt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/itt_ctrl.sv =====
// Controller for the implicit tree traversal: insert decode and walk sequencer.
// Depends on itt_pkg.
`timescale 1ns / 1ps

module itt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  itt_pkg::dp_status_t status_i,
  output itt_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  typedef enum logic [1:0] {
    PhEnter,
    PhLeftDone,
    PhRightDone
  } phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  itt_pkg::order_e order_q, order_d;
  logic            emit;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    order_d = order_q;
    cmd_o   = '{wr_node: 1'b0, set_err: 1'b0, rd_node: 1'b0,
                pos_op: itt_pkg::PosHold, tag_order: order_q,
                tag_last: 1'b0};
    cmd_o.tag_last = (order_q == itt_pkg::OrdPost) && (phase_q == PhRightDone) &&
                     status_i.at_root;
    in_ready_o = (state_q == StIdle) && status_i.pend_free;
    emit       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (command_i == itt_pkg::CmdDump) begin
            if (!status_i.empty) begin
              cmd_o.pos_op = itt_pkg::PosRoot;
              state_d      = StWalk;
              phase_d      = PhEnter;
              order_d      = itt_pkg::OrdPre;
            end
          end else if (status_i.full) begin
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.wr_node = 1'b1;
          end
        end
      end
      StWalk: begin
        unique case (phase_q)
          PhEnter:     emit = (order_q == itt_pkg::OrdPre);
          PhLeftDone:  emit = (order_q == itt_pkg::OrdIn);
          PhRightDone: emit = (order_q == itt_pkg::OrdPost);
          default:     emit = 1'b0;
        endcase
        // Hold the walk at an emitting step while the pending stage cannot take another read.
        if (!emit || status_i.pend_free) begin
          cmd_o.rd_node = emit;
          unique case (phase_q)
            PhEnter: begin
              if (status_i.has_left) begin
                cmd_o.pos_op = itt_pkg::PosLeft;
              end else begin
                phase_d = PhLeftDone;
              end
            end
            PhLeftDone: begin
              if (status_i.has_right) begin
                cmd_o.pos_op = itt_pkg::PosRight;
                phase_d      = PhEnter;
              end else begin
                phase_d = PhRightDone;
              end
            end
            PhRightDone: begin
              if (status_i.at_root) begin
                unique case (order_q)
                  itt_pkg::OrdPre: begin
                    order_d = itt_pkg::OrdIn;
                    phase_d = PhEnter;
                  end
                  itt_pkg::OrdIn: begin
                    order_d = itt_pkg::OrdPost;
                    phase_d = PhEnter;
                  end
                  default: state_d = StIdle;
                endcase
              end else begin
                cmd_o.pos_op = itt_pkg::PosUp;
                phase_d = status_i.is_left_child ? PhLeftDone : PhRightDone;
              end
            end
            default: phase_d = PhEnter;
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhEnter;
      order_q <= itt_pkg::OrdPre;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      order_q <= order_d;
    end
  end

endmodule

// ===== hw/rtl/itt_datapath.sv =====
// Datapath for the implicit tree traversal: node store, position, result stages.
// Depends on itt_pkg and itt_ram.
`timescale 1ns / 1ps

module itt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [itt_pkg::CountW-1:0]   cfg_data_i,
  input  logic signed [31:0]           value_i,
  input  itt_pkg::ctl_cmd_t            cmd_i,
  output itt_pkg::dp_status_t          status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output itt_pkg::out_beat_t           out_data_o
);

  logic [itt_pkg::CountW-1:0] capacity_q, count_q, count_d, limit, pos_q, pos_d;
  logic [itt_pkg::CountW:0]   left_pos, right_pos;
  logic [itt_pkg::AddrW-1:0]  rd_addr;
  logic [itt_pkg::CountW-1:0] pos_m1;
  logic [31:0]                rdata;

  logic                       pend_q, pend_err_q, pend_last_q;
  itt_pkg::order_e            pend_order_q;
  logic signed [31:0]         pend_val_q;
  logic                       out_valid_q;
  itt_pkg::out_beat_t         out_q;
  logic                       out_free, pend_move;

  assign limit = (capacity_q > itt_pkg::CountW'(itt_pkg::MaxNodes)) ?
                 itt_pkg::CountW'(itt_pkg::MaxNodes) : capacity_q;

  assign left_pos  = {pos_q, 1'b0};
  assign right_pos = {pos_q, 1'b1};
  assign pos_m1    = pos_q - itt_pkg::CountW'(1);
  assign rd_addr   = pos_m1[itt_pkg::AddrW-1:0];

  assign out_free  = !out_valid_q || out_ready_i;
  assign pend_move = pend_q && out_free;

  assign status_o.full          = (count_q >= limit);
  assign status_o.empty         = (count_q == '0);
  assign status_o.has_left      = (left_pos <= {1'b0, count_q});
  assign status_o.has_right     = (right_pos <= {1'b0, count_q});
  assign status_o.at_root       = (pos_q == itt_pkg::CountW'(1));
  assign status_o.is_left_child = !pos_q[0];
  assign status_o.pend_free     = !pend_q || out_free;

  itt_ram #(
    .Width(32),
    .Depth(itt_pkg::MaxNodes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_node),
    .waddr_i(count_q[itt_pkg::AddrW-1:0]),
    .wdata_i(value_i),
    .re_i   (cmd_i.rd_node),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_node) begin
      count_d = count_q + itt_pkg::CountW'(1);
    end
    unique case (cmd_i.pos_op)
      itt_pkg::PosRoot:  pos_d = itt_pkg::CountW'(1);
      itt_pkg::PosLeft:  pos_d = left_pos[itt_pkg::CountW-1:0];
      itt_pkg::PosRight: pos_d = right_pos[itt_pkg::CountW-1:0];
      itt_pkg::PosUp:    pos_d = pos_q >> 1;
      default:           pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= itt_pkg::CountW'(itt_pkg::MaxNodes);
      count_q     <= '0;
      pos_q       <= itt_pkg::CountW'(1);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      count_q <= count_d;
      pos_q   <= pos_d;
      if (cmd_i.rd_node || cmd_i.set_err) begin
        pend_q <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload stages: the pending stage carries tags while the store read completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_node || cmd_i.set_err) begin
      pend_err_q   <= cmd_i.set_err;
      pend_order_q <= cmd_i.set_err ? itt_pkg::OrdPre : cmd_i.tag_order;
      pend_last_q  <= cmd_i.set_err ? 1'b0 : cmd_i.tag_last;
      pend_val_q   <= value_i;
    end
    if (pend_move) begin
      out_q.node_value <= pend_err_q ? pend_val_q : $signed(rdata);
      out_q.order      <= pend_order_q;
      out_q.last       <= pend_last_q;
      out_q.full_error <= pend_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/implicit_tree_traversal.sv =====
// Top level of the implicit tree traversal block.
// Depends on itt_pkg, itt_ctrl, itt_datapath and implicit_tree_traversal_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one beat is a command. Insert
//     appends the value at the next level-order position; dump walks the tree.
//   out channel (out_valid_o/out_ready_i/out_data_o): result beats. A rejected
//     insert (tree at min(capacity, 16) nodes) gives one beat with full_error set.
//     A dump gives 3*N beats: preorder, inorder, postorder, last set on the final.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes capacity; always
//     ready. Write it only while the block is idle.
// Timing:
//   An accepted insert is written at its accepting edge; inserts can follow back to back.
//   A rejected insert passes the pending stage, then the output register, to out_valid_o.
//   A dump takes three sequencer steps per node per order (enter, after left,
//   after right); each emitted node then passes the store read and the output
//   register. The walk sequencer steps one node phase a cycle while not stalled.
// Reset: node count clears to zero, capacity returns to 16, no beat is pending.
// Stall: when out_ready_i is low the output register holds its beat; the walk
//   stalls only at steps that would emit, and in_ready_o drops until space frees.

module implicit_tree_traversal (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  itt_pkg::in_beat_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output itt_pkg::out_beat_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [itt_pkg::CountW-1:0] cfg_data_i
);

  `include "implicit_tree_traversal_assert.svh"

  itt_pkg::ctl_cmd_t   cmd;
  itt_pkg::dp_status_t status;

  // Capacity is a plain register write, so the port never back-pressures.
  assign cfg_ready_o = 1'b1;

  // Sequencer: decodes commands and steps the walk one node phase per cycle unless stalled.
  itt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i (in_data_i.command),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Store, node count, walk position, pending read stage and output register.
  itt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .value_i    (in_data_i.value),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // A store read is issued only when the pending stage can take it.
  `ITT_ASSERT_IMPL(a_read_has_room, cmd.rd_node, status.pend_free)
  // No walk read while the input side is open.
  `ITT_ASSERT_IMPL(a_no_read_when_idle, in_ready_o, !cmd.rd_node)
  // Rejections and writes follow the fill level.
  `ITT_ASSERT_IMPL(a_err_only_full, cmd.set_err, status.full)
  `ITT_ASSERT_IMPL(a_write_not_full, cmd.wr_node, !status.full)
  // An error beat carries order OrdPre and never has last set.
  `ITT_ASSERT_IMPL(a_err_beat_clean, out_valid_o && out_data_o.full_error,
                   out_data_o.order == itt_pkg::OrdPre && !out_data_o.last)

endmodule
